### rtl/core/skfh_pkg.sv
package skfh_pkg;

	// Field widths.
	localparam int BYTE_W = 8;
	localparam int ROW_W  = 48;
	localparam int HASH_W = 64;

	// Number of substitution table entries, one per byte value.
	localparam int TABLE_ENTRIES = 256;

	// FNV-1a 64-bit offset basis.
	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;

	// Item operation codes.
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_ABSORB = 2'd1,
		OP_END    = 2'd2
	} op_t;

	// Command passed from the front end to the hash engine.
	typedef struct packed {
		logic              is_end;
		logic [BYTE_W-1:0] sub_byte;
		logic [ROW_W-1:0]  row;
	} cmd_t;

	// Multiply by the FNV prime 0x100000001b3 modulo 2^64.
	// The prime is 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0.
	function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
		fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

### rtl/core/substituted_fnv1a64_key_hash.sv
// Streaming 64-bit FNV-1a hasher with a 256-entry byte substitution table in front.
// Each input beat is a table load, an absorbed byte, an end of record or an ignored op
// code; an end of record returns the hash with its row id and restarts the hash at the
// offset basis. The block takes one beat per clock, sustained, for any mix of operations,
// as long as results are taken; an end beat passes the table read stage and the command
// queue, and the hash engine then loads its output register from the queue head, which
// raises out_valid. The rate is set by the hash loop, which does the XOR and the sparse
// multiply by the prime combinationally, and by the single-port table read, one per beat.
// The table is the identity right after reset with no clearing pass, since each entry
// carries a loaded flag. A table load affects bytes accepted after it.
module substituted_fnv1a64_key_hash #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [skfh_pkg::BYTE_W-1:0] entry_index,
	input  logic [skfh_pkg::BYTE_W-1:0] entry_value,
	input  logic [skfh_pkg::BYTE_W-1:0] data_byte,
	input  logic [skfh_pkg::ROW_W-1:0]  row_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [skfh_pkg::HASH_W-1:0] key_hash,
	output logic [skfh_pkg::ROW_W-1:0]  row_out
);

	logic           fe_valid;
	logic           fe_ready;
	skfh_pkg::cmd_t fe_cmd;
	logic           be_valid;
	logic           be_ready;
	skfh_pkg::cmd_t be_cmd;

	// Front end: decode, table loads and lookups.
	skfh_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.data_byte   (data_byte),
		.row_id      (row_id),
		.cmd_valid   (fe_valid),
		.cmd_ready   (fe_ready),
		.cmd         (fe_cmd)
	);

	// Command queue between the two halves.
	skfh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_data  (fe_cmd),
		.pop_valid  (be_valid),
		.pop_ready  (be_ready),
		.pop_data   (be_cmd)
	);

	// Hash engine and result register.
	skfh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (be_valid),
		.cmd_ready (be_ready),
		.cmd       (be_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_hash  (key_hash),
		.row_out   (row_out)
	);

endmodule

### rtl/core/skfh_front.sv
module skfh_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     op,
	input  logic [skfh_pkg::BYTE_W-1:0]    entry_index,
	input  logic [skfh_pkg::BYTE_W-1:0]    entry_value,
	input  logic [skfh_pkg::BYTE_W-1:0]    data_byte,
	input  logic [skfh_pkg::ROW_W-1:0]     row_id,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output skfh_pkg::cmd_t                 cmd
);

	skfh_pkg::op_t op_dec;
	logic          accept;
	logic          do_write;
	logic          do_read;
	logic          do_pass;

	logic [skfh_pkg::BYTE_W-1:0] table_mem [skfh_pkg::TABLE_ENTRIES];
	logic [skfh_pkg::TABLE_ENTRIES-1:0] written_q;
	logic [skfh_pkg::BYTE_W-1:0] rd_data_q;
	logic                        rd_written_q;

	logic                        valid_s1;
	logic                        is_end_s1;
	logic [skfh_pkg::BYTE_W-1:0] byte_s1;
	logic [skfh_pkg::ROW_W-1:0]  row_s1;

	// Decode the beat and decide what it does.
	assign op_dec   = skfh_pkg::op_t'(op);
	assign in_ready = !valid_s1 || cmd_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		do_write = 1'b0;
		do_read  = 1'b0;
		do_pass  = 1'b0;
		unique case (op_dec)
			skfh_pkg::OP_WRITE: begin
				do_write = accept;
			end
			skfh_pkg::OP_ABSORB: begin
				do_read = accept;
				do_pass = accept;
			end
			skfh_pkg::OP_END: begin
				do_pass = accept;
			end
			default: begin
				do_write = 1'b0;
			end
		endcase
	end

	// Substitution table storage with a registered read port.
	always_ff @(posedge clk) begin
		if (do_write) begin
			table_mem[entry_index] <= entry_value;
		end
		if (do_read) begin
			rd_data_q    <= table_mem[data_byte];
			rd_written_q <= written_q[data_byte];
		end
	end

	// An entry that was never loaded reads as the identity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (do_write) begin
			written_q[entry_index] <= 1'b1;
		end
	end

	// Stage register that waits for the table read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= do_pass;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pass) begin
			is_end_s1 <= (op_dec == skfh_pkg::OP_END);
			byte_s1   <= data_byte;
			row_s1    <= row_id;
		end
	end

	// Command toward the hash engine.
	assign cmd_valid     = valid_s1;
	assign cmd.is_end    = is_end_s1;
	assign cmd.sub_byte  = rd_written_q ? rd_data_q : byte_s1;
	assign cmd.row       = row_s1;

endmodule

### rtl/core/skfh_queue.sv
module skfh_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  skfh_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output skfh_pkg::cmd_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	skfh_pkg::cmd_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/skfh_back.sv
module skfh_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  skfh_pkg::cmd_t              cmd,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [skfh_pkg::HASH_W-1:0] key_hash,
	output logic [skfh_pkg::ROW_W-1:0]  row_out
);

	logic [skfh_pkg::HASH_W-1:0] hash_q;
	logic [skfh_pkg::HASH_W-1:0] mixed;
	logic                        out_valid_q;
	logic [skfh_pkg::HASH_W-1:0] key_hash_q;
	logic [skfh_pkg::ROW_W-1:0]  row_out_q;
	logic                        absorb;
	logic                        finish;

	// Absorbs never stall; an end waits for room in the output register.
	assign cmd_ready = !cmd.is_end || !out_valid_q || out_ready;
	assign absorb    = cmd_valid && !cmd.is_end;
	assign finish    = cmd_valid && cmd.is_end && cmd_ready;

	// One FNV-1a round: XOR in the substitute, then the sparse prime multiply.
	assign mixed = skfh_pkg::fnv_mul(hash_q ^ {{(skfh_pkg::HASH_W-skfh_pkg::BYTE_W){1'b0}},
		cmd.sub_byte});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= skfh_pkg::FNV_BASIS;
		end else if (finish) begin
			hash_q <= skfh_pkg::FNV_BASIS;
		end else if (absorb) begin
			hash_q <= mixed;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			key_hash_q <= hash_q;
			row_out_q  <= cmd.row;
		end
	end

	assign out_valid = out_valid_q;
	assign key_hash  = key_hash_q;
	assign row_out   = row_out_q;

endmodule

### tb/tb_top.sv
module tb_top;

	typedef logic [skfh_pkg::BYTE_W-1:0] byte_t;
	typedef logic [skfh_pkg::ROW_W-1:0]  row_t;
	typedef logic [skfh_pkg::HASH_W-1:0] hash_t;

	// Prime of the 64-bit FNV hash; the package carries only the basis.
	localparam hash_t FNV_PRIME = 64'h0000_0100_0000_01b3;
	// Op code that the block must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		hash_t key;
		row_t  row;
	} key_rec_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] op = skfh_pkg::OP_WRITE;
	byte_t      entry_index = '0;
	byte_t      entry_value = '0;
	byte_t      data_byte = '0;
	row_t       row_id = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	hash_t      key_hash;
	row_t       row_out;

	// Shadow copy of the substitution table and the running hash.
	byte_t    subst_map [skfh_pkg::TABLE_ENTRIES];
	hash_t    hash_acc;
	key_rec_t pending_keys [$];

	int  fail_count = 0;
	int  cycle_count = 0;
	int  sink_hold = 0;
	bit  src_gaps = 1'b1;
	bit  sink_stalls = 1'b1;

	substituted_fnv1a64_key_hash u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.data_byte   (data_byte),
		.row_id      (row_id),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_hash    (key_hash),
		.row_out     (row_out)
	);

	// Clock with a 12-unit period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Cycle counter that stops a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: ready drops in random bursts while stalls are enabled.
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			out_ready <= (sink_hold == 1);
		end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
			sink_hold <= $urandom_range(1, 9);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each accepted result beat with the oldest predicted key.
	always @(posedge clk) begin : check_results
		key_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_keys.size() == 0) begin
				$display("%0t: unexpected result, actual key_hash %h row_out %h",
					$time, key_hash, row_out);
				fail_count++;
			end else begin
				want = pending_keys.pop_front();
				if (key_hash !== want.key) begin
					$display("%0t: key_hash expected %h actual %h", $time, want.key, key_hash);
					fail_count++;
				end
				if (row_out !== want.row) begin
					$display("%0t: row_out expected %h actual %h", $time, want.row, row_out);
					fail_count++;
				end
			end
		end
	end

	// Update the shadow state for one accepted beat and queue any result.
	task automatic predict_beat(input logic [1:0] code, input byte_t idx,
			input byte_t val, input byte_t dbyte, input row_t row);
		key_rec_t rec;
		case (code)
			skfh_pkg::OP_WRITE: begin
				subst_map[idx] = val;
			end
			skfh_pkg::OP_ABSORB: begin
				hash_acc = (hash_acc ^ {{(skfh_pkg::HASH_W-skfh_pkg::BYTE_W){1'b0}},
					subst_map[dbyte]}) * FNV_PRIME;
			end
			skfh_pkg::OP_END: begin
				rec.key = hash_acc;
				rec.row = row;
				pending_keys.insert(pending_keys.size(), rec);
				hash_acc = skfh_pkg::FNV_BASIS;
			end
			default: begin
			end
		endcase
	endtask

	// Present one beat, hold it until accepted, then predict its effect.
	// Valid stays high on return so a back-to-back beat needs no second update.
	task automatic send_beat(input logic [1:0] code, input byte_t idx,
			input byte_t val, input byte_t dbyte, input row_t row);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		entry_index <= idx;
		entry_value <= val;
		data_byte <= dbyte;
		row_id <= row;
		do @(posedge clk); while (!in_ready);
		predict_beat(code, idx, val, dbyte, row);
	endtask

	function automatic row_t pick_row();
		case ($urandom_range(0, 9))
			0: pick_row = '0;
			1: pick_row = '1;
			default: pick_row = row_t'({$urandom, $urandom});
		endcase
	endfunction

	// Fields that an op does not use are filled with random values.
	task automatic put_byte(input byte_t dbyte);
		send_beat(skfh_pkg::OP_ABSORB, byte_t'($urandom), byte_t'($urandom), dbyte,
			row_t'({$urandom, $urandom}));
	endtask

	task automatic close_record(input row_t row);
		send_beat(skfh_pkg::OP_END, byte_t'($urandom), byte_t'($urandom),
			byte_t'($urandom), row);
	endtask

	task automatic load_entry(input byte_t idx, input byte_t val);
		send_beat(skfh_pkg::OP_WRITE, idx, val, byte_t'($urandom),
			row_t'({$urandom, $urandom}));
	endtask

	task automatic send_noise();
		send_beat(OP_UNUSED, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
			row_t'({$urandom, $urandom}));
	endtask

	// Drop valid and hold off until every predicted key has been returned.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_keys.size() != 0) @(posedge clk);
	endtask

	task automatic apply_reset();
		int i;
		for (i = 0; i < skfh_pkg::TABLE_ENTRIES; i++) subst_map[i] = i[skfh_pkg::BYTE_W-1:0];
		hash_acc = skfh_pkg::FNV_BASIS;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// An end with nothing absorbed must return the basis, with row extremes.
	task automatic test_empty_record();
		close_record('0);
		close_record('1);
	endtask

	// Byte extremes and alternating patterns through the identity table.
	task automatic test_identity_bytes();
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'h55);
		put_byte(8'hAA);
		close_record(pick_row());
	endtask

	// Table loads at the index and value extremes, including one mid-record.
	task automatic test_table_load();
		load_entry(8'h00, 8'hFF);
		load_entry(8'hFF, 8'h00);
		load_entry(8'hAA, 8'h55);
		put_byte(8'h00);
		put_byte(8'hFF);
		load_entry(8'h00, 8'h00);
		put_byte(8'h00);
		put_byte(8'hAA);
		close_record(pick_row());
		load_entry(8'hAA, 8'hAA);
		load_entry(8'hFF, 8'hFF);
	endtask

	// The unused op must leave the hash and the table alone.
	task automatic test_unused_op();
		put_byte(8'h07);
		send_noise();
		close_record(pick_row());
		send_noise();
		close_record(pick_row());
	endtask

	// Records of random length and content, with scattered table loads and
	// unused-op noise. Noise beats do not count toward the goal.
	task automatic run_records(input int beat_goal);
		int sent;
		int len;
		int k;
		sent = 0;
		while (sent < beat_goal) begin
			len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
			for (k = 0; k < len; k++) begin
				if ($urandom_range(0, 19) == 0) begin
					load_entry(byte_t'($urandom), byte_t'($urandom));
					sent++;
				end
				if ($urandom_range(0, 29) == 0) send_noise();
				put_byte(byte_t'($urandom));
				sent++;
			end
			close_record(pick_row());
			sent++;
		end
	endtask

	// Random records with idling on both sides and one full drain midway.
	task automatic test_random_records();
		run_records(600);
		wait_drained();
		run_records(500);
	endtask

	// Final stretch at full rate on both sides.
	task automatic test_steady_stream();
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		run_records(300);
	endtask

	initial begin
		apply_reset();
		test_empty_record();
		test_identity_bytes();
		test_table_load();
		test_unused_op();
		test_random_records();
		test_steady_stream();
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
